// ===== rtl/mpc_pkg.sv =====
// shared types, constants and helpers of the pseudocolor compositor
package mpc_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int COMP_W      = 8;
  localparam int RGB_W       = 24;
  localparam int PROD_W      = SAMPLE_W + COMP_W;
  localparam int HW_CHANNELS = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int MASK_W      = HW_CHANNELS;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COMP_W-1:0]   comp_t;
  typedef logic [RGB_W-1:0]    rgb_t;
  typedef logic [PROD_W-1:0]   prod_t;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_CH0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_CH1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_CH2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_CH3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_MASK = 3'd4;

  localparam rgb_t                COLOR_CH0_RST = 24'hff0000;
  localparam rgb_t                COLOR_CH1_RST = 24'h00ff00;
  localparam rgb_t                COLOR_CH2_RST = 24'hff0000;
  localparam rgb_t                COLOR_CH3_RST = 24'h00ff00;
  localparam logic [MASK_W-1:0]   VISIBLE_RST   = 4'hf;

  // per-stage advance enables of the pipeline
  typedef struct packed {
    logic en_mul;
    logic en_div;
    logic en_out;
  } stage_en_t;

  // floor(p / 255), exact for p up to 255*255
  function automatic comp_t div255(input prod_t p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + {{(SAMPLE_W+1){1'b0}}, p[PROD_W-1:COMP_W]} + {{PROD_W{1'b0}}, 1'b1};
    return t[PROD_W-1:COMP_W];
  endfunction

endpackage

// ===== rtl/mpc_lane.sv =====
// one channel lane: scales the channel color by its sample
module mpc_lane (
  input  logic               clk,
  input  mpc_pkg::stage_en_t ctrl,
  input  mpc_pkg::sample_t   sample,
  input  mpc_pkg::rgb_t      color,
  input  logic               visible,
  output mpc_pkg::rgb_t      scaled
);

  mpc_pkg::prod_t prod_r [3];
  mpc_pkg::rgb_t  scaled_r;

  // component k sits at bits 8k+7..8k, blue is k = 0
  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= visible ?
          mpc_pkg::prod_t'(sample) * mpc_pkg::prod_t'(color[k*mpc_pkg::COMP_W +: mpc_pkg::COMP_W])
          : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_div) begin
      for (int k = 0; k < 3; k++) begin
        scaled_r[k*mpc_pkg::COMP_W +: mpc_pkg::COMP_W] <= mpc_pkg::div255(prod_r[k]);
      end
    end
  end

  assign scaled = scaled_r;

endmodule

// ===== rtl/mpc_merge.sv =====
// merging stage: per-component maximum over the lanes, registered
module mpc_merge #(
  parameter int LANES = 4
) (
  input  logic               clk,
  input  mpc_pkg::stage_en_t ctrl,
  input  mpc_pkg::rgb_t      lane_rgb [LANES],
  output mpc_pkg::rgb_t      pixel
);

  mpc_pkg::rgb_t merged;
  mpc_pkg::rgb_t pixel_r;

  // hidden lanes read as black; with disjoint colors at most one lane is
  // nonzero per component, so the maximum equals the sum
  always_comb begin
    mpc_pkg::comp_t best;
    mpc_pkg::comp_t cur;
    merged = '0;
    for (int k = 0; k < 3; k++) begin
      best = '0;
      for (int l = 0; l < LANES; l++) begin
        cur = lane_rgb[l][k*mpc_pkg::COMP_W +: mpc_pkg::COMP_W];
        if (cur > best) begin
          best = cur;
        end
      end
      merged[k*mpc_pkg::COMP_W +: mpc_pkg::COMP_W] = best;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_out) begin
      pixel_r <= merged;
    end
  end

  assign pixel = pixel_r;

endmodule

// ===== rtl/multichannel_pseudocolor_compositor.sv =====
// Pipeline: an accepted in_ beat passes the multiply, divide and merge stages to out_tvalid,
// the three registered stages of the per-channel lanes and merge unit.
// Throughput: one pixel beat per cycle while out_tready is high; each stage has its
// own valid and advances whenever the stage after it is empty or moving, so bubbles collapse.
// Reset: rst_n synchronous active low clears stage valids and loads the
// color and visibility registers with their defaults; no clearing pass.
module multichannel_pseudocolor_compositor #(
  parameter int CHANNELS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // slave stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // sample_0, sample_1, sample_2, sample_3
  // master stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // pixel_rgb
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [23:0]                     cfg_data
);

  localparam int LANES = (CHANNELS < mpc_pkg::HW_CHANNELS) ? CHANNELS : mpc_pkg::HW_CHANNELS;

  mpc_pkg::rgb_t             color_r [mpc_pkg::HW_CHANNELS];
  logic [mpc_pkg::MASK_W-1:0] visible_r;

  logic v_mul_r, v_div_r, v_out_r;
  mpc_pkg::stage_en_t ctrl;
  logic in_fire;

  mpc_pkg::rgb_t lane_rgb [LANES];
  mpc_pkg::rgb_t pixel;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r[0] <= mpc_pkg::COLOR_CH0_RST;
      color_r[1] <= mpc_pkg::COLOR_CH1_RST;
      color_r[2] <= mpc_pkg::COLOR_CH2_RST;
      color_r[3] <= mpc_pkg::COLOR_CH3_RST;
      visible_r  <= mpc_pkg::VISIBLE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpc_pkg::REG_COLOR_CH0:    color_r[0] <= cfg_data;
        mpc_pkg::REG_COLOR_CH1:    color_r[1] <= cfg_data;
        mpc_pkg::REG_COLOR_CH2:    color_r[2] <= cfg_data;
        mpc_pkg::REG_COLOR_CH3:    color_r[3] <= cfg_data;
        mpc_pkg::REG_VISIBLE_MASK: visible_r  <= cfg_data[mpc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.en_out = !v_out_r || out_tready;
    ctrl.en_div = !v_div_r || ctrl.en_out;
    ctrl.en_mul = !v_mul_r || ctrl.en_div;
  end

  assign in_tready = ctrl.en_mul && rst_n;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r <= 1'b0;
      v_div_r <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (ctrl.en_mul) begin
        v_mul_r <= in_fire;
      end
      if (ctrl.en_div) begin
        v_div_r <= v_mul_r;
      end
      if (ctrl.en_out) begin
        v_out_r <= v_div_r;
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mpc_lane u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .sample  (in_tdata[g*mpc_pkg::SAMPLE_W +: mpc_pkg::SAMPLE_W]),
      .color   (color_r[g]),
      .visible (visible_r[g]),
      .scaled  (lane_rgb[g])
    );
  end

  mpc_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .ctrl     (ctrl),
    .lane_rgb (lane_rgb),
    .pixel    (pixel)
  );

  assign out_tvalid = v_out_r;
  assign out_tdata  = pixel;

endmodule
